/* rtl/core/nacu_pkg.sv */
// Shared types and constants for the NAT address checksum update block
package nacu_pkg;

    localparam int WORD_W        = 16;
    localparam int NUM_WORDS     = 8;
    localparam int ADDR_W        = WORD_W * NUM_WORDS;
    localparam int V4_FIRST_WORD = 6;

    localparam logic [7:0] PROTO_TCP   = 8'd6;
    localparam logic [7:0] PROTO_UDP   = 8'd17;
    localparam logic [7:0] PROTO_ICMP6 = 8'd58;

    typedef struct packed {
        logic                v6;
        logic                hdr_en;
        logic                tp_en;
        logic [WORD_W-1:0]   hsum;
        logic [WORD_W-1:0]   tsum;
        logic [ADDR_W-1:0]   orig_ip;
        logic [ADDR_W-1:0]   repl_ip;
    } stage_t;

endpackage

/* rtl/core/nacu_req_if.sv */
// Request channel: address rewrite transaction with valid/ready handshake
interface nacu_req_if;
    logic        valid;
    logic        ready;
    logic        is_v6;
    logic        rewrite_source;
    logic [63:0] old_src_high;
    logic [63:0] old_src_low;
    logic [63:0] old_dst_high;
    logic [63:0] old_dst_low;
    logic [63:0] new_addr_high;
    logic [63:0] new_addr_low;
    logic [15:0] ip_header_sum;
    logic [15:0] transport_sum;
    logic [7:0]  proto_number;
    logic [12:0] fragment_offset;

    modport source (
        output valid, is_v6, rewrite_source, old_src_high, old_src_low,
               old_dst_high, old_dst_low, new_addr_high, new_addr_low,
               ip_header_sum, transport_sum, proto_number, fragment_offset,
        input  ready
    );

    modport sink (
        input  valid, is_v6, rewrite_source, old_src_high, old_src_low,
               old_dst_high, old_dst_low, new_addr_high, new_addr_low,
               ip_header_sum, transport_sum, proto_number, fragment_offset,
        output ready
    );
endinterface

/* rtl/core/nacu_rsp_if.sv */
// Response channel: updated checksums with valid/ready handshake
interface nacu_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] new_ip_header_sum;
    logic [15:0] new_transport_sum;
    logic        transport_changed;

    modport source (
        output valid, new_ip_header_sum, new_transport_sum, transport_changed,
        input  ready
    );

    modport sink (
        input  valid, new_ip_header_sum, new_transport_sum, transport_changed,
        output ready
    );
endinterface

/* rtl/core/nat_address_checksum_update.sv */
// Top level: NAT address rewrite checksum updater built as a chain of word cells
//
//   channel | modport | contents
//   --------+---------+---------------------------------------------------
//   req     | sink    | old src/dst addresses, new address, sums, protocol
//   rsp     | source  | updated header sum, transport sum, changed flag
//
// One transaction enters per cycle while rsp is not stalled; each result passes
// through the 8-cell chain, one cell per 16-bit address word.
// Reset clears only the per-cell valid bits.
// A stalled rsp holds the whole chain; req.ready follows rsp.ready when the
// last cell is full.
module nat_address_checksum_update (
    input  logic       clk,
    input  logic       rst_n,
    nacu_req_if.sink   req,
    nacu_rsp_if.source rsp
);

    logic                         en;
    logic                         tp_proto_v4;
    logic                         tp_proto_v6;
    nacu_pkg::stage_t             head;
    logic [nacu_pkg::NUM_WORDS:0] vchain;
    nacu_pkg::stage_t             dchain [nacu_pkg::NUM_WORDS+1];

    assign en        = !vchain[nacu_pkg::NUM_WORDS] || rsp.ready;
    assign req.ready = en;

    assign tp_proto_v4 = (req.proto_number == nacu_pkg::PROTO_TCP)
                      || (req.proto_number == nacu_pkg::PROTO_UDP);
    assign tp_proto_v6 = tp_proto_v4 || (req.proto_number == nacu_pkg::PROTO_ICMP6);

    always_comb
    begin
        head.v6      = req.is_v6;
        head.hdr_en  = !req.is_v6;
        head.tp_en   = req.is_v6 ? tp_proto_v6
                                 : (tp_proto_v4 && (req.fragment_offset == 13'd0));
        head.hsum    = req.ip_header_sum;
        head.tsum    = req.transport_sum;
        head.orig_ip = req.rewrite_source ? {req.old_src_high, req.old_src_low}
                                          : {req.old_dst_high, req.old_dst_low};
        head.repl_ip = {req.new_addr_high, req.new_addr_low};
    end

    assign vchain[0] = req.valid;
    assign dchain[0] = head;

    for (genvar k = 0; k < nacu_pkg::NUM_WORDS; k++)
    begin : g_cell
        nacu_cell #(
            .IDX (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (vchain[k]),
            .in_data   (dchain[k]),
            .out_valid (vchain[k+1]),
            .out_data  (dchain[k+1])
        );
    end

    assign rsp.valid             = vchain[nacu_pkg::NUM_WORDS];
    assign rsp.new_ip_header_sum = dchain[nacu_pkg::NUM_WORDS].hsum;
    assign rsp.new_transport_sum = dchain[nacu_pkg::NUM_WORDS].tsum;
    assign rsp.transport_changed = dchain[nacu_pkg::NUM_WORDS].tp_en;

endmodule

/* rtl/core/nacu_cell.sv */
// One checksum cell: applies a single 16-bit address word and passes the transaction on
module nacu_cell #(
    parameter int IDX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  nacu_pkg::stage_t in_data,
    output logic            out_valid,
    output nacu_pkg::stage_t out_data
);

    localparam bit IN_V4_SPAN = (IDX >= nacu_pkg::V4_FIRST_WORD);

    logic                        valid_reg;
    nacu_pkg::stage_t            data_reg;
    nacu_pkg::stage_t            data_next;
    logic [nacu_pkg::WORD_W-1:0] old_word;
    logic [nacu_pkg::WORD_W-1:0] new_word;
    logic                        hdr_go;
    logic                        tp_go;

    function automatic logic [nacu_pkg::WORD_W-1:0] word_update(
        input logic [nacu_pkg::WORD_W-1:0] oldw,
        input logic [nacu_pkg::WORD_W-1:0] neww,
        input logic [nacu_pkg::WORD_W-1:0] sum
    );
        logic [31:0] c;
        logic [31:0] f;
        c = {16'h0, sum} - {16'h0, ~oldw} - {16'h0, neww};
        f = {16'h0, c[31:16]} + {16'h0, c[15:0]};
        f = f + {16'h0, f[31:16]};
        return f[15:0];
    endfunction

    assign old_word = in_data.orig_ip[nacu_pkg::ADDR_W-1 -: nacu_pkg::WORD_W];
    assign new_word = in_data.repl_ip[nacu_pkg::ADDR_W-1 -: nacu_pkg::WORD_W];
    assign hdr_go   = in_data.hdr_en && IN_V4_SPAN;
    assign tp_go    = in_data.tp_en && (in_data.v6 || IN_V4_SPAN);

    always_comb
    begin
        data_next         = in_data;
        data_next.orig_ip = {in_data.orig_ip[nacu_pkg::ADDR_W-nacu_pkg::WORD_W-1:0],
                             {nacu_pkg::WORD_W{1'b0}}};
        data_next.repl_ip = {in_data.repl_ip[nacu_pkg::ADDR_W-nacu_pkg::WORD_W-1:0],
                             {nacu_pkg::WORD_W{1'b0}}};
        if (hdr_go)
        begin
            data_next.hsum = word_update(old_word, new_word, in_data.hsum);
        end
        if (tp_go)
        begin
            data_next.tsum = word_update(old_word, new_word, in_data.tsum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
